@@ hdl/pbwf_pkg.sv @@
// Shared types and constants for the protobuf wire field parser.
// No dependencies; imported by every module of the block.
package pbwf_pkg;

  localparam int unsigned MAX_MSG_BYTES_DEF = 65536;
  localparam int unsigned MSG_LEN_W         = 17;

  // Result kinds.
  typedef enum logic [2:0] {
    EV_TAG     = 3'd0,
    EV_VARINT  = 3'd1,
    EV_FIXED64 = 3'd2,
    EV_FIXED32 = 3'd3,
    EV_LENGTH  = 3'd4,
    EV_PAYLOAD = 3'd5,
    EV_ERROR   = 3'd6
  } pbwf_event_e;

  // Error codes.
  typedef enum logic [2:0] {
    ERR_TRUNC        = 3'd0,
    ERR_VARINT_OVF   = 3'd1,
    ERR_LEN_LONG     = 3'd2,
    ERR_GROUP        = 3'd3,
    ERR_WIRE_UNKNOWN = 3'd4
  } pbwf_err_e;

  // Wire types.
  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_I64    = 3'd1;
  localparam logic [2:0] WT_LEN    = 3'd2;
  localparam logic [2:0] WT_SGROUP = 3'd3;
  localparam logic [2:0] WT_EGROUP = 3'd4;
  localparam logic [2:0] WT_I32    = 3'd5;

  // Parse phase, one-hot.
  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_TAG     = 7'b0000010,
    PH_VARINT  = 7'b0000100,
    PH_FIXED   = 7'b0001000,
    PH_LEN     = 7'b0010000,
    PH_PAYLOAD = 7'b0100000,
    PH_DISCARD = 7'b1000000
  } pbwf_phase_e;

  // One input beat.
  typedef struct packed {
    logic [7:0]           byte_value;
    logic                 first_of_message;
    logic [MSG_LEN_W-1:0] message_length;
  } pbwf_beat_t;

  // One result beat.
  typedef struct packed {
    pbwf_event_e event_kind;
    logic [31:0] field_number;
    logic [2:0]  wire_type;
    logic [63:0] field_value;
    logic        field_done;
    logic        message_done;
    pbwf_err_e   error_code;
  } pbwf_result_t;

endpackage

@@ hdl/pbwf_in_stage.sv @@
// Input register for the protobuf wire field parser.
// Depends on pbwf_pkg (beat struct).
module pbwf_in_stage
  import pbwf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  pbwf_beat_t beat_i,
  input  logic       out_free_i,   // result slot can take a new beat
  output logic       advance_o,    // held beat is consumed this cycle
  output pbwf_beat_t beat_o
);

  logic       valid_q, valid_d;
  pbwf_beat_t beat_q;
  logic       load;

  assign advance_o  = valid_q && out_free_i;
  assign in_stall_o = valid_q && !out_free_i;
  assign load       = in_valid_i && !in_stall_o;
  assign beat_o     = beat_q;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q <= beat_i;
    end
  end

endmodule

@@ hdl/pbwf_decode.sv @@
// Parse state and per-byte decode of the protobuf wire field parser.
// Depends on pbwf_pkg (phase, event, error types and beat/result structs).
module pbwf_decode
  import pbwf_pkg::*;
#(
  parameter int unsigned MAX_MESSAGE_BYTES = MAX_MSG_BYTES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  pbwf_beat_t   beat_i,
  input  logic         take_i,
  output logic         has_result_o,
  output pbwf_result_t result_o
);

  localparam int unsigned CNT_W = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int unsigned LW    = (CNT_W > MSG_LEN_W) ? CNT_W : MSG_LEN_W;

  pbwf_phase_e      ph_q, n_ph;
  logic [63:0]      acc_q, n_acc;
  logic [3:0]       vcnt_q, n_vcnt;
  logic [2:0]       fcnt_q, n_fcnt;
  logic [31:0]      fld_q, n_fld;
  logic [2:0]       wt_q, n_wt;
  logic [CNT_W-1:0] pl_q, n_pl;
  logic [CNT_W-1:0] rem_q, n_rem;

  always_comb begin
    logic [LW-1:0]    len_x;
    logic [CNT_W-1:0] rem_dec;
    logic [CNT_W-1:0] pl_dec;
    logic             last;
    logic             skip;
    logic [6:0]       vshift;
    logic [3:0]       vcnt_inc;
    logic [63:0]      acc_v;
    logic [63:0]      acc_f;
    logic [2:0]       need_m1;
    logic             fixed_done;
    logic             do_put;
    logic             do_fin;
    logic             do_err;
    pbwf_event_e      kind;
    pbwf_err_e        code;
    logic [63:0]      val;

    n_ph   = ph_q;
    n_acc  = acc_q;
    n_vcnt = vcnt_q;
    n_fcnt = fcnt_q;
    n_fld  = fld_q;
    n_wt   = wt_q;
    n_pl   = pl_q;
    n_rem  = rem_q;
    do_put = 1'b0;
    do_fin = 1'b0;
    do_err = 1'b0;
    kind   = EV_TAG;
    code   = ERR_TRUNC;
    val    = '0;
    skip   = 1'b0;

    // Length clamp: zero counts as one, saturate at the maximum.
    len_x = LW'(beat_i.message_length);
    if (len_x == '0) begin
      len_x = LW'(1);
    end
    if (len_x > LW'(MAX_MESSAGE_BYTES)) begin
      len_x = LW'(MAX_MESSAGE_BYTES);
    end

    if (beat_i.first_of_message) begin
      n_ph   = PH_TAG;
      n_acc  = '0;
      n_vcnt = '0;
      n_fcnt = '0;
      n_fld  = '0;
      n_wt   = '0;
      n_pl   = '0;
      n_rem  = CNT_W'(len_x);
    end else if (ph_q == PH_IDLE || rem_q == '0) begin
      skip = 1'b1;
      n_ph = PH_IDLE;
    end

    rem_dec  = n_rem - CNT_W'(1);
    last     = (rem_dec == '0);
    vshift   = 7'(n_vcnt) * 7'd7;
    vcnt_inc = n_vcnt + 4'd1;
    acc_v    = n_acc;
    if (n_vcnt < 4'd10) begin
      acc_v = n_acc | (64'(beat_i.byte_value[6:0]) << vshift);
    end
    acc_f      = n_acc | (64'(beat_i.byte_value) << {n_fcnt, 3'b000});
    need_m1    = (n_wt == WT_I64) ? 3'd7 : 3'd3;
    fixed_done = (n_fcnt == need_m1);
    pl_dec     = (n_pl == '0) ? '0 : n_pl - CNT_W'(1);

    if (!skip) begin
      n_rem = rem_dec;
      case (n_ph)
        PH_TAG, PH_VARINT, PH_LEN: begin
          n_acc  = acc_v;
          n_vcnt = vcnt_inc;
          if (beat_i.byte_value[7]) begin
            if (vcnt_inc >= 4'd10) begin
              do_err = 1'b1;
              code   = ERR_VARINT_OVF;
            end else if (last) begin
              do_err = 1'b1;
              code   = ERR_TRUNC;
            end
          end else begin
            n_acc  = '0;
            n_vcnt = '0;
            if (n_ph == PH_TAG) begin
              n_fld = acc_v[34:3];
              n_wt  = acc_v[2:0];
              if (acc_v[2:0] == WT_SGROUP || acc_v[2:0] == WT_EGROUP) begin
                do_err = 1'b1;
                code   = ERR_GROUP;
              end else if (acc_v[2:0] > WT_I32) begin
                do_err = 1'b1;
                code   = ERR_WIRE_UNKNOWN;
              end else if (last) begin
                do_err = 1'b1;
                code   = ERR_TRUNC;
              end else begin
                do_put = 1'b1;
                kind   = EV_TAG;
                val    = acc_v;
                n_fcnt = '0;
                if (acc_v[2:0] == WT_VARINT) begin
                  n_ph = PH_VARINT;
                end else if (acc_v[2:0] == WT_LEN) begin
                  n_ph = PH_LEN;
                end else begin
                  n_ph = PH_FIXED;
                end
              end
            end else if (n_ph == PH_VARINT) begin
              do_fin = 1'b1;
              kind   = EV_VARINT;
              val    = acc_v;
            end else if (acc_v > 64'(rem_dec)) begin
              do_err = 1'b1;
              code   = ERR_LEN_LONG;
              val    = acc_v;
            end else if (acc_v == '0) begin
              do_fin = 1'b1;
              kind   = EV_LENGTH;
            end else begin
              do_put = 1'b1;
              kind   = EV_LENGTH;
              val    = acc_v;
              n_pl   = CNT_W'(acc_v);
              n_ph   = PH_PAYLOAD;
            end
          end
        end
        PH_FIXED: begin
          n_acc  = acc_f;
          n_fcnt = n_fcnt + 3'd1;
          if (fixed_done) begin
            do_fin = 1'b1;
            kind   = (n_wt == WT_I64) ? EV_FIXED64 : EV_FIXED32;
            val    = acc_f;
          end else if (last) begin
            do_err = 1'b1;
            code   = ERR_TRUNC;
          end
        end
        PH_PAYLOAD: begin
          n_pl = pl_dec;
          if (pl_dec == '0) begin
            do_fin = 1'b1;
            kind   = EV_PAYLOAD;
            val    = 64'(beat_i.byte_value);
          end else if (last) begin
            do_err = 1'b1;
            code   = ERR_TRUNC;
          end else begin
            do_put = 1'b1;
            kind   = EV_PAYLOAD;
            val    = 64'(beat_i.byte_value);
          end
        end
        default: begin
          // discarding the tail of a failed message
          if (last) begin
            n_ph = PH_IDLE;
          end
        end
      endcase
    end

    if (do_err) begin
      kind = EV_ERROR;
    end

    // Field number and wire type as seen after the tag update.
    result_o.event_kind   = kind;
    result_o.field_number = n_fld;
    result_o.wire_type    = n_wt;
    result_o.field_value  = val;
    result_o.field_done   = do_fin;
    result_o.message_done = do_fin && last;
    result_o.error_code   = do_err ? code : ERR_TRUNC;
    has_result_o          = do_put || do_fin || do_err;

    if (do_err || do_fin) begin
      n_acc  = '0;
      n_vcnt = '0;
      n_fcnt = '0;
      n_pl   = '0;
    end
    if (do_err) begin
      n_ph = last ? PH_IDLE : PH_DISCARD;
    end
    if (do_fin) begin
      n_fld = '0;
      n_wt  = '0;
      n_ph  = last ? PH_IDLE : PH_TAG;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      acc_q  <= '0;
      vcnt_q <= '0;
      fcnt_q <= '0;
      fld_q  <= '0;
      wt_q   <= '0;
      pl_q   <= '0;
      rem_q  <= '0;
    end else if (take_i) begin
      ph_q   <= n_ph;
      acc_q  <= n_acc;
      vcnt_q <= n_vcnt;
      fcnt_q <= n_fcnt;
      fld_q  <= n_fld;
      wt_q   <= n_wt;
      pl_q   <= n_pl;
      rem_q  <= n_rem;
    end
  end

endmodule

@@ hdl/pbwf_out_stage.sv @@
// Result register for the protobuf wire field parser.
// Depends on pbwf_pkg (result struct).
module pbwf_out_stage
  import pbwf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  pbwf_result_t result_i,
  input  logic         out_stall_i,
  output logic         out_valid_o,
  output logic         out_free_o,
  output pbwf_result_t result_o
);

  logic         valid_q, valid_d;
  pbwf_result_t result_q;

  assign out_free_o  = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign result_o    = result_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

endmodule

@@ hdl/protobuf_wire_field_parser.sv @@
// Top level of the protobuf wire field parser: input register, decode, result register.
// Depends on pbwf_pkg, pbwf_in_stage, pbwf_decode and pbwf_out_stage.
//
//   channel | handshake               | beat contents
//   --------+-------------------------+-----------------------------------------------
//   in      | in_valid_i / in_stall_o | byte_value_i, first_of_message_i,
//           |                         | message_length_i
//   out     | out_valid_o/out_stall_i | event_kind_o, field_number_o, wire_type_o,
//           |                         | field_value_o, field_done_o, message_done_o,
//           |                         | error_code_o
//
// One byte per cycle while no result beat is stalled. An accepted byte is held in the
// input register, decoded against the parse state there and, if it yields a beat,
// loaded into the result register once the result slot is free; out_valid_o then rises.
// Bytes that yield no beat (varint continuation, fixed, idle, discarded) only move state.
// in_stall_o rises only while out_stall_i holds a waiting result beat.
// Reset (rst_ni low, asynchronous) clears both valid flags and the parse state to idle.
module protobuf_wire_field_parser
  import pbwf_pkg::*;
#(
  parameter int unsigned MAX_MESSAGE_BYTES = MAX_MSG_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           byte_value_i,
  input  logic                 first_of_message_i,
  input  logic [MSG_LEN_W-1:0] message_length_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           event_kind_o,
  output logic [31:0]          field_number_o,
  output logic [2:0]           wire_type_o,
  output logic [63:0]          field_value_o,
  output logic                 field_done_o,
  output logic                 message_done_o,
  output logic [2:0]           error_code_o
);

  pbwf_beat_t   in_beat;
  pbwf_beat_t   held_beat;
  pbwf_result_t dec_result;
  pbwf_result_t out_result;
  logic         advance;
  logic         out_free;
  logic         has_result;

  assign in_beat.byte_value       = byte_value_i;
  assign in_beat.first_of_message = first_of_message_i;
  assign in_beat.message_length   = message_length_i;

  pbwf_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .beat_i     (in_beat),
    .out_free_i (out_free),
    .advance_o  (advance),
    .beat_o     (held_beat)
  );

  // Parse state moves only when the held byte is consumed.
  pbwf_decode #(
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
  ) u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_i       (held_beat),
    .take_i       (advance),
    .has_result_o (has_result),
    .result_o     (dec_result)
  );

  pbwf_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && has_result),
    .result_i    (dec_result),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_free_o  (out_free),
    .result_o    (out_result)
  );

  assign event_kind_o   = out_result.event_kind;
  assign field_number_o = out_result.field_number;
  assign wire_type_o    = out_result.wire_type;
  assign field_value_o  = out_result.field_value;
  assign field_done_o   = out_result.field_done;
  assign message_done_o = out_result.message_done;
  assign error_code_o   = out_result.error_code;

endmodule

@@ hdl/pbwf_checker.sv @@
// Port-level assertions for the protobuf wire field parser, bound to the top level.
// Depends on pbwf_pkg (event kinds) and protobuf_wire_field_parser.
module pbwf_checker
  import pbwf_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic [7:0]           byte_value_i,
  input logic                 first_of_message_i,
  input logic [MSG_LEN_W-1:0] message_length_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [2:0]           event_kind_o,
  input logic [31:0]          field_number_o,
  input logic [2:0]           wire_type_o,
  input logic [63:0]          field_value_o,
  input logic                 field_done_o,
  input logic                 message_done_o,
  input logic [2:0]           error_code_o
);

  // A stalled result beat stays.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // Input is only held back by a stalled result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled with output free");

  // An error never completes a field or message.
  a_err_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o == EV_ERROR |-> !field_done_o && !message_done_o)
    else $error("error beat flagged done");

  // Message end is always at a field end, with no error code.
  a_msg_at_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_done_o |-> field_done_o && error_code_o == ERR_TRUNC)
    else $error("message done off a field boundary");

endmodule

bind protobuf_wire_field_parser pbwf_checker u_pbwf_checker (.*);

@@ dv/testbench.sv @@
// Self-checking testbench for protobuf_wire_field_parser: byte stream in, field beats out.
// Depends on pbwf_pkg and the parser RTL; carries its own bit-exact wire-format predictor.
`timescale 1ns / 1ps

module testbench;
  import pbwf_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat moving on either channel
  localparam int RANDOM_BYTES   = 520;   // rough size of the random stream
  localparam int CALM_TAIL      = 60;    // last bytes are sent with no idling on either side
  localparam int DRAIN_CYCLES   = 20;    // extra wait after the queues empty, catches strays

  logic                 clk_i              = 1'b0;
  logic                 rst_ni             = 1'b0;
  logic                 in_valid_i         = 1'b0;
  logic                 in_stall_o;
  logic [7:0]           byte_value_i       = '0;
  logic                 first_of_message_i = 1'b0;
  logic [MSG_LEN_W-1:0] message_length_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i        = 1'b0;
  logic [2:0]           event_kind_o;
  logic [31:0]          field_number_o;
  logic [2:0]           wire_type_o;
  logic [63:0]          field_value_o;
  logic                 field_done_o;
  logic                 message_done_o;
  logic [2:0]           error_code_o;

  protobuf_wire_field_parser dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .byte_value_i       (byte_value_i),
    .first_of_message_i (first_of_message_i),
    .message_length_i   (message_length_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .event_kind_o       (event_kind_o),
    .field_number_o     (field_number_o),
    .wire_type_o        (wire_type_o),
    .field_value_o      (field_value_o),
    .field_done_o       (field_done_o),
    .message_done_o     (message_done_o),
    .error_code_o       (error_code_o)
  );

  // ---------------------------------------------------------------------------
  // Stimulus and scoreboard storage
  // ---------------------------------------------------------------------------
  pbwf_beat_t   pending_bytes[$];  // bytes waiting for the driver
  pbwf_result_t expected_beats[$]; // predicted output beats, oldest first
  logic [7:0]   msg_body[$];       // message under construction
  int           stream_bytes = 0;  // bytes queued that belong to some message

  // Shadow of the parser state
  pbwf_phase_e          sh_phase    = PH_IDLE;
  logic [63:0]          sh_acc      = '0;
  logic [3:0]           sh_vcnt     = '0;
  logic [3:0]           sh_fcnt     = '0;  // counts to 8 for fixed64
  logic [31:0]          sh_field    = '0;
  logic [2:0]           sh_wtype    = '0;
  logic [MSG_LEN_W-1:0] sh_pay_left = '0;
  logic [MSG_LEN_W-1:0] sh_remain   = '0;

  pbwf_result_t predicted;
  pbwf_result_t drv_predicted;
  pbwf_result_t observed;
  pbwf_beat_t   next_byte;

  int gap_left     = 0;
  int stall_left   = 0;
  int quiet_cycles = 0;
  int mismatches   = 0;
  int bytes_in     = 0;
  int msgs_started = 0;
  int beats_seen   = 0;
  int error_beats  = 0;

  // ---------------------------------------------------------------------------
  // Wire-format predictor
  // ---------------------------------------------------------------------------
  function automatic pbwf_result_t make_beat(pbwf_event_e kind, logic [63:0] value,
                                             logic fdone, logic mdone, pbwf_err_e code);
    pbwf_result_t r;
    r.event_kind   = kind;
    r.field_number = sh_field;
    r.wire_type    = sh_wtype;
    r.field_value  = value;
    r.field_done   = fdone;
    r.message_done = mdone;
    r.error_code   = code;
    return r;
  endfunction

  // Error beat; the rest of the message is dropped unless this was its last byte.
  function automatic pbwf_result_t fail_field(pbwf_err_e code, logic [63:0] value, bit last);
    pbwf_result_t r;
    r = make_beat(EV_ERROR, value, 1'b0, 1'b0, code);
    sh_acc      = '0;
    sh_vcnt     = '0;
    sh_fcnt     = '0;
    sh_pay_left = '0;
    if (last) sh_phase = PH_IDLE;
    else sh_phase = PH_DISCARD;
    return r;
  endfunction

  // Field-closing beat; the error code reads as zero (ERR_TRUNC) on good beats.
  function automatic pbwf_result_t close_field(pbwf_event_e kind, logic [63:0] value, bit last);
    pbwf_result_t r;
    r = make_beat(kind, value, 1'b1, last, ERR_TRUNC);
    sh_acc      = '0;
    sh_vcnt     = '0;
    sh_fcnt     = '0;
    sh_pay_left = '0;
    sh_field    = '0;
    sh_wtype    = '0;
    if (last) sh_phase = PH_IDLE;
    else sh_phase = PH_TAG;
    return r;
  endfunction

  // Consumes one accepted byte; returns 1 when it produces an output beat.
  function automatic bit parse_byte(logic [7:0] b, logic first, logic [MSG_LEN_W-1:0] mlen,
                                    output pbwf_result_t r);
    logic [MSG_LEN_W-1:0] n;
    logic [63:0]          v;
    bit                   last;
    int                   need;
    r = '0;
    if (first) begin
      // zero length counts as one byte, oversize saturates
      n = mlen;
      if (n == '0) n = MSG_LEN_W'(1);
      if (n > MAX_MSG_BYTES_DEF) n = MAX_MSG_BYTES_DEF[MSG_LEN_W-1:0];
      sh_remain   = n;
      sh_phase    = PH_TAG;
      sh_acc      = '0;
      sh_vcnt     = '0;
      sh_fcnt     = '0;
      sh_field    = '0;
      sh_wtype    = '0;
      sh_pay_left = '0;
    end else if (sh_phase == PH_IDLE || sh_remain == 0) begin
      sh_phase = PH_IDLE;
      return 1'b0;
    end
    sh_remain = sh_remain - 1'b1;
    last = (sh_remain == 0);

    case (sh_phase)
      PH_TAG, PH_VARINT, PH_LEN: begin
        if (sh_vcnt < 10) sh_acc = sh_acc | (64'(b[6:0]) << (7 * sh_vcnt));
        sh_vcnt = sh_vcnt + 1'b1;
        if (b[7]) begin
          if (sh_vcnt >= 10) begin
            r = fail_field(ERR_VARINT_OVF, '0, last);
            return 1'b1;
          end
          if (last) begin
            r = fail_field(ERR_TRUNC, '0, last);
            return 1'b1;
          end
          return 1'b0;
        end
        v = sh_acc;
        sh_acc  = '0;
        sh_vcnt = '0;
        if (sh_phase == PH_TAG) begin
          sh_field = v[34:3];
          sh_wtype = v[2:0];
          // wire type checks come ahead of truncation
          if (sh_wtype == WT_SGROUP || sh_wtype == WT_EGROUP) begin
            r = fail_field(ERR_GROUP, '0, last);
          end else if (sh_wtype > WT_I32) begin
            r = fail_field(ERR_WIRE_UNKNOWN, '0, last);
          end else if (last) begin
            r = fail_field(ERR_TRUNC, '0, last);
          end else begin
            r = make_beat(EV_TAG, v, 1'b0, 1'b0, ERR_TRUNC);
            if (sh_wtype == WT_VARINT) sh_phase = PH_VARINT;
            else if (sh_wtype == WT_LEN) sh_phase = PH_LEN;
            else sh_phase = PH_FIXED;
            sh_fcnt = '0;
          end
          return 1'b1;
        end
        if (sh_phase == PH_VARINT) begin
          r = close_field(EV_VARINT, v, last);
        end else if (v > 64'(sh_remain)) begin
          r = fail_field(ERR_LEN_LONG, v, last);
        end else if (v == 0) begin
          r = close_field(EV_LENGTH, '0, last);
        end else begin
          r = make_beat(EV_LENGTH, v, 1'b0, 1'b0, ERR_TRUNC);
          sh_pay_left = v[MSG_LEN_W-1:0];
          sh_phase    = PH_PAYLOAD;
        end
        return 1'b1;
      end
      PH_FIXED: begin
        if (sh_wtype == WT_I64) need = 8;
        else need = 4;
        sh_acc  = sh_acc | (64'(b) << (8 * sh_fcnt[2:0]));
        sh_fcnt = sh_fcnt + 1'b1;
        if (sh_fcnt >= need) begin
          if (need == 8) r = close_field(EV_FIXED64, sh_acc, last);
          else r = close_field(EV_FIXED32, sh_acc, last);
          return 1'b1;
        end
        if (last) begin
          r = fail_field(ERR_TRUNC, '0, last);
          return 1'b1;
        end
        return 1'b0;
      end
      PH_PAYLOAD: begin
        if (sh_pay_left > 0) sh_pay_left = sh_pay_left - 1'b1;
        if (sh_pay_left == 0) r = close_field(EV_PAYLOAD, 64'(b), last);
        else if (last) r = fail_field(ERR_TRUNC, '0, last);
        else r = make_beat(EV_PAYLOAD, 64'(b), 1'b0, 1'b0, ERR_TRUNC);
        return 1'b1;
      end
      default: begin
        // discarding after an error
        if (last) sh_phase = PH_IDLE;
        return 1'b0;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Message builders
  // ---------------------------------------------------------------------------

  // Appends a varint, padded with continuation bytes up to min_bytes. Bits of
  // top_junk land in a tenth byte; all but its low bit lie past bit 63, where the parser drops them.
  function automatic void add_varint(logic [63:0] v, int min_bytes, logic [6:0] top_junk);
    logic [63:0] x;
    x = v;
    for (int n = 1; n <= 10; n++) begin
      if (n == 10) begin
        msg_body.push_back({1'b0, x[6:0] | top_junk});
        break;
      end
      if ((x >> 7) == 0 && n >= min_bytes) begin
        msg_body.push_back({1'b0, x[6:0]});
        break;
      end
      msg_body.push_back({1'b1, x[6:0]});
      x = x >> 7;
    end
  endfunction

  function automatic int pick_pad();
    if ($urandom_range(0, 9) == 0) return $urandom_range(1, 10);
    return 1;
  endfunction

  function automatic logic [63:0] pick_tag(logic [2:0] wt);
    logic [63:0] t;
    case ($urandom_range(0, 9))
      0:       t = {29'b0, 32'($urandom), wt};    // full 32-bit field numbers
      1:       t = {$urandom, $urandom};          // bits past the field number width
      default: t = {56'b0, 5'($urandom), wt};     // short tags, field numbers below 32
    endcase
    t[2:0] = wt;
    return t;
  endfunction

  // Appends one field; a rough field is malformed on purpose.
  function automatic void add_field(bit rough);
    logic [63:0] v;
    logic [2:0]  wt;
    int          plen;
    if (rough) begin
      case ($urandom_range(0, 3))
        0: begin
          // group or unknown wire type, trailed by junk
          case ($urandom_range(0, 3))
            0:       wt = WT_SGROUP;
            1:       wt = WT_EGROUP;
            2:       wt = 3'd6;
            default: wt = 3'd7;
          endcase
          add_varint(pick_tag(wt), pick_pad(), '0);
          repeat ($urandom_range(0, 3)) msg_body.push_back(8'($urandom));
        end
        1: begin
          // ten continuation bytes in a row
          add_varint(pick_tag(WT_VARINT), 1, '0);
          repeat (10) msg_body.push_back({1'b1, 7'($urandom)});
        end
        2: begin
          // length larger than the message can hold
          add_varint(pick_tag(WT_LEN), 1, '0);
          add_varint(64'($urandom_range(20, 70000)), pick_pad(), '0);
          repeat ($urandom_range(0, 3)) msg_body.push_back(8'($urandom));
        end
        default: begin
          // varint left open
          add_varint(pick_tag(WT_VARINT), 1, '0);
          msg_body.push_back({1'b1, 7'($urandom)});
        end
      endcase
      return;
    end
    case ($urandom_range(0, 3))
      0: begin
        add_varint(pick_tag(WT_VARINT), pick_pad(), '0);
        v = {$urandom, $urandom} >> $urandom_range(0, 64);
        if ($urandom_range(0, 7) == 0) add_varint(v, 10, 7'($urandom));
        else add_varint(v, pick_pad(), '0);
      end
      1: begin
        add_varint(pick_tag(WT_I64), pick_pad(), '0);
        repeat (8) msg_body.push_back(8'($urandom));
      end
      2: begin
        add_varint(pick_tag(WT_LEN), pick_pad(), '0);
        if ($urandom_range(0, 9) == 0) plen = $urandom_range(9, 40);
        else plen = $urandom_range(0, 8);
        add_varint(64'(plen), pick_pad(), '0);
        repeat (plen) msg_body.push_back(8'($urandom));
      end
      default: begin
        add_varint(pick_tag(WT_I32), pick_pad(), '0);
        repeat (4) msg_body.push_back(8'($urandom));
      end
    endcase
  endfunction

  // Queues msg_body as one message; the length rides on the first byte only.
  function automatic void push_body(logic [MSG_LEN_W-1:0] len);
    pending_bytes.push_back({msg_body[0], 1'b1, len});
    for (int i = 1; i < msg_body.size(); i++)
      pending_bytes.push_back({msg_body[i], 1'b0, MSG_LEN_W'($urandom)});
    stream_bytes += msg_body.size();
  endfunction

  function automatic void send_message(bit rough);
    int len;
    msg_body.delete();
    repeat ($urandom_range(1, 4)) add_field(rough && $urandom_range(0, 2) == 0);
    len = msg_body.size();
    if (rough) begin
      case ($urandom_range(0, 3))
        0: len = $urandom_range(1, len);          // ends early, tail ignored
        1: len = len + $urandom_range(1, 4);      // next start cuts it off
        2: begin
          // declared whole, sent partly
          repeat ($urandom_range(0, msg_body.size() - 1)) void'(msg_body.pop_back());
        end
        default: ;
      endcase
    end
    push_body(MSG_LEN_W'(len));
  endfunction

  function automatic bit winding_down();
    return pending_bytes.size() < CALM_TAIL;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset, stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    // Directed part: extremes and the listed corner cases
    pending_bytes.push_back({8'h55, 1'b0, MSG_LEN_W'(0)});  // stray byte outside a message
    msg_body = '{8'h08};
    push_body('0);                  // length zero read as one: tag on last byte truncates
    msg_body = '{8'h1B};
    push_body(MSG_LEN_W'(1));       // group type beats truncation
    msg_body = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F};
    push_body(MSG_LEN_W'(65536));   // 29-bit all-ones field number, wire type 7
    msg_body = '{8'h08, 8'h96, 8'h01};
    push_body(MSG_LEN_W'(3));       // clean varint field ends the message
    msg_body = '{8'h12, 8'hFD, 8'hFF, 8'h03};
    push_body('1);                  // saturated length: 65533 is one too many
    msg_body = '{8'h0D, 8'h00};
    push_body(MSG_LEN_W'(2));       // new start abandons the above; fixed32 truncated
    msg_body = '{8'h0A, 8'h00};
    push_body(MSG_LEN_W'(2));       // empty length-delimited field
    msg_body = '{8'h32, 8'h02, 8'hAB};
    push_body(MSG_LEN_W'(3));       // length longer than the rest of the message

    // Random part: mostly well-formed messages, some broken, some noise
    while (stream_bytes < RANDOM_BYTES) begin
      case ($urandom_range(0, 19))
        0: begin
          msg_body.delete();
          repeat ($urandom_range(1, 12)) msg_body.push_back(8'($urandom));
          push_body(MSG_LEN_W'($urandom));
        end
        1: repeat ($urandom_range(1, 3))
             pending_bytes.push_back({8'($urandom), 1'b0, MSG_LEN_W'($urandom)});
        2, 3, 4: send_message(1'b1);
        default: send_message(1'b0);
      endcase
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_bytes.size() > 0 || in_valid_i || expected_beats.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d bytes over %0d message starts, %0d output beats (%0d errors).",
             bytes_in, msgs_started, beats_seen, error_beats);
    $display("Mismatched or unexpected beats: %0d, beats never seen: %0d.",
             mismatches, expected_beats.size());
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: predicts each accepted byte, then loads the next one or idles.
  // Valid only drops after acceptance, so a stalled byte stays put.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        bytes_in++;
        if (first_of_message_i) msgs_started++;
        if (parse_byte(byte_value_i, first_of_message_i, message_length_i, drv_predicted))
          expected_beats.push_back(drv_predicted);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_bytes.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (!winding_down() && $urandom_range(0, 11) == 0) begin
          gap_left = $urandom_range(0, 13);   // start a burst of idle cycles
          in_valid_i <= 1'b0;
        end else begin
          next_byte = pending_bytes.pop_front();
          in_valid_i         <= 1'b1;
          byte_value_i       <= next_byte.byte_value;
          first_of_message_i <= next_byte.first_of_message;
          message_length_i   <= next_byte.message_length;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each accepted output beat against the oldest prediction
  // and drives out_stall_i in random bursts.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        beats_seen++;
        observed.event_kind   = pbwf_event_e'(event_kind_o);
        observed.field_number = field_number_o;
        observed.wire_type    = wire_type_o;
        observed.field_value  = field_value_o;
        observed.field_done   = field_done_o;
        observed.message_done = message_done_o;
        observed.error_code   = pbwf_err_e'(error_code_o);
        if (observed.event_kind == EV_ERROR) error_beats++;
        if (expected_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d: unexpected kind=%0d fn=%0h wt=%0d val=%0h", beats_seen,
                     event_kind_o, field_number_o, wire_type_o, field_value_o);
        end else begin
          predicted = expected_beats.pop_front();
          if (observed !== predicted) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("beat %0d mismatch (kind fn wt val fdone mdone err):", beats_seen);
              $display("  exp %0d %0h %0d %0h %0b %0b %0d", predicted.event_kind,
                       predicted.field_number, predicted.wire_type, predicted.field_value,
                       predicted.field_done, predicted.message_done, predicted.error_code);
              $display("  got %0d %0h %0d %0h %0b %0b %0d", event_kind_o, field_number_o,
                       wire_type_o, field_value_o, field_done_o, message_done_o,
                       error_code_o);
            end
          end
        end
      end
      if (winding_down()) begin
        out_stall_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 13);   // start a burst of stalled cycles
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog: too long with no beat moving on either channel ends the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: %0d cycles without progress", quiet_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

endmodule
